/* hdl/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg
// shared constants, register codes and control types of the 2x2 box
// downsampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bds_pkg;

  // default build limits
  localparam int MaxWidth    = 2048;
  localparam int MaxHeight   = 2048;
  localparam int ChannelBits = 16;

  // fixed field and register widths
  localparam int FieldW  = 16;
  localparam int SizeW   = 12;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  localparam logic [SizeW-1:0] SizeReset = 12'd2048;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // what the raster position means for the item being taken
  typedef struct packed {
    logic pair_first;  // even column: starts a horizontal pair
    logic store;       // odd column of an even row: pair sum goes to the line store
    logic emit;        // odd column of an odd row: block completes
    logic last;        // bottom-right pixel of the frame
  } pos_t;

endpackage

/* hdl/bds_stream_if.sv */
// ----------------------------------------------------------------------------
// bds_stream_if
// valid/ready channels for input pixels and averaged output pixels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bds_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bds_pkg::FieldW-1:0]  red_in;
  logic [bds_pkg::FieldW-1:0]  green_in;
  logic [bds_pkg::FieldW-1:0]  blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface bds_res_if;
  logic                        valid;
  logic                        ready;
  logic [bds_pkg::FieldW-1:0]  red_out;
  logic [bds_pkg::FieldW-1:0]  green_out;
  logic [bds_pkg::FieldW-1:0]  blue_out;
  logic                        last_of_frame;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output last_of_frame, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input last_of_frame, output ready);
endinterface

/* hdl/bds_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bds_cfg_regs
// apb register file for frame width and height, gives the effective even
// sizes clamped to the build limits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bds_cfg_regs #(
  parameter int MAX_WIDTH  = bds_pkg::MaxWidth,
  parameter int MAX_HEIGHT = bds_pkg::MaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bds_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bds_pkg::ApbDataW-1:0]  pwdata,
  output logic [bds_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output logic [bds_pkg::SizeW-1:0]     frame_w_o,
  output logic [bds_pkg::SizeW-1:0]     frame_h_o
);

  localparam int SW = bds_pkg::SizeW;
  localparam int MaxSize = (1 << SW) - 2;

  // largest even size the effective width and height may take
  localparam int WLimRaw = ((MAX_WIDTH / 2) * 2 == 0) ? 2 : (MAX_WIDTH / 2) * 2;
  localparam int HLimRaw = ((MAX_HEIGHT / 2) * 2 == 0) ? 2 : (MAX_HEIGHT / 2) * 2;
  localparam logic [SW-1:0] WLim = SW'((WLimRaw > MaxSize) ? MaxSize : WLimRaw);
  localparam logic [SW-1:0] HLim = SW'((HLimRaw > MaxSize) ? MaxSize : HLimRaw);

  logic [SW-1:0]          width_q, width_d;
  logic [SW-1:0]          height_q, height_d;
  logic                   wr_en;
  bds_pkg::reg_idx_e      reg_idx;

  function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] r,
                                             input logic [SW-1:0] lim);
    logic [SW-1:0] v;
    v = {r[SW-1:1], 1'b0};
    if (v == '0) v = SW'(2);
    if (v > lim) v = lim;
    return v;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = bds_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (reg_idx)
        bds_pkg::REG_FRAME_WIDTH:  width_d  = pwdata[SW-1:0];
        bds_pkg::REG_FRAME_HEIGHT: height_d = pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bds_pkg::SizeReset;
      height_q <= bds_pkg::SizeReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    case (reg_idx)
      bds_pkg::REG_FRAME_WIDTH:  prdata = bds_pkg::ApbDataW'(width_q);
      bds_pkg::REG_FRAME_HEIGHT: prdata = bds_pkg::ApbDataW'(height_q);
      default:                   prdata = '0;
    endcase
  end

  assign frame_w_o = eff_size(width_q, WLim);
  assign frame_h_o = eff_size(height_q, HLim);

endmodule

/* hdl/bds_raster_ctrl.sv */
// ----------------------------------------------------------------------------
// bds_raster_ctrl
// column and row counters of the input raster, decodes what each item does
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bds_raster_ctrl #(
  parameter int ADDR_W = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [bds_pkg::SizeW-1:0]  frame_w_i,
  input  logic [bds_pkg::SizeW-1:0]  frame_h_i,
  output bds_pkg::pos_t              pos_o,
  output logic [ADDR_W-1:0]          slot_o
);

  localparam int SW = bds_pkg::SizeW;

  logic [SW-1:0] col_q, col_d;
  logic [SW-1:0] row_q, row_d;
  logic [SW-1:0] col_inc, row_inc;
  logic          col_wrap, row_wrap;

  assign col_inc  = SW'(col_q + 1'b1);
  assign row_inc  = SW'(row_q + 1'b1);
  assign col_wrap = (col_inc >= frame_w_i);
  assign row_wrap = (row_inc >= frame_h_i);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (adv_i) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_inc;
      end else begin
        col_d = col_inc;
        // height shrank below the current row
        if (row_q >= frame_h_i) row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.pair_first = ~col_q[0];
  assign pos_o.store      = col_q[0] & ~row_q[0];
  assign pos_o.emit       = col_q[0] & row_q[0];
  assign pos_o.last       = col_wrap & row_wrap;
  assign slot_o           = ADDR_W'(col_q >> 1);

endmodule

/* hdl/bds_line_mem.sv */
// ----------------------------------------------------------------------------
// bds_line_mem
// line store of pair sums, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bds_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 51
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/box_downsample_2x2.sv */
// the bottom-right pixel of a block loads stage 1 and the line store read, then
// the add feeds the output register (held while the output stalls)
// one pixel per cycle unless output stalls, at most one store access per item
// the line store is never read and written in the same cycle, so no forwarding
// reset clears counters and pipeline valids; sizes return to 2048, line store
// contents are left as they are
// ----------------------------------------------------------------------------
// box_downsample_2x2
// 2x2 box filter downsampler for an rgb raster stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_downsample_2x2 #(
  parameter int MAX_WIDTH    = bds_pkg::MaxWidth,
  parameter int MAX_HEIGHT   = bds_pkg::MaxHeight,
  parameter int CHANNEL_BITS = bds_pkg::ChannelBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bds_pix_if.sink                       pix_i,
  bds_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bds_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bds_pkg::ApbDataW-1:0]  pwdata,
  output logic [bds_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int FW        = bds_pkg::FieldW;
  localparam int CW        = (CHANNEL_BITS < FW) ? CHANNEL_BITS : FW;
  localparam int SUM_W     = CW + 1;
  localparam int TOT_W     = CW + 2;
  localparam int MEM_W     = 3 * SUM_W;
  localparam int LineDepth = (MAX_WIDTH / 2 < 1) ? 1 : MAX_WIDTH / 2;
  localparam int ADDR_W    = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  logic [bds_pkg::SizeW-1:0] frame_w, frame_h;
  bds_pkg::pos_t             pos;
  logic [ADDR_W-1:0]         slot;

  logic in_acc, out_free;
  logic mem_we, mem_re;

  logic [CW-1:0]    in_ch  [3];
  logic [CW-1:0]    pair_q [3];
  logic [SUM_W-1:0] sum_c  [3];
  logic [MEM_W-1:0] mem_wdata, mem_rdata;

  logic             s1_valid_q;
  logic [SUM_W-1:0] s1_sum_q [3];
  logic             s1_last_q;

  logic [TOT_W-1:0] total [3];
  logic             out_valid_q;
  logic [FW-1:0]    out_q [3];
  logic             out_last_q;

  bds_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .frame_w_o (frame_w),
    .frame_h_o (frame_h)
  );

  bds_raster_ctrl #(
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (in_acc),
    .frame_w_i (frame_w),
    .frame_h_i (frame_h),
    .pos_o     (pos),
    .slot_o    (slot)
  );

  // handshake: a new item may enter while stage 1 is empty or moving on
  assign out_free    = ~out_valid_q | res_o.ready;
  assign pix_i.ready = ~s1_valid_q | out_free;
  assign in_acc      = pix_i.valid & pix_i.ready;

  assign in_ch[0] = pix_i.red_in[CW-1:0];
  assign in_ch[1] = pix_i.green_in[CW-1:0];
  assign in_ch[2] = pix_i.blue_in[CW-1:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = SUM_W'(pair_q[c]) + SUM_W'(in_ch[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && pos.pair_first) begin
      for (int c = 0; c < 3; c++) pair_q[c] <= in_ch[c];
    end
  end

  assign mem_wdata = {sum_c[2], sum_c[1], sum_c[0]};
  assign mem_we    = in_acc & pos.store;
  assign mem_re    = in_acc & pos.emit;

  bds_line_mem #(
    .DEPTH  (LineDepth),
    .ADDR_W (ADDR_W),
    .DATA_W (MEM_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (slot),
    .rdata_o (mem_rdata)
  );

  // stage 1: bottom pair sum waits for the line store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (mem_re) begin
      s1_valid_q <= 1'b1;
    end else if (out_free) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      for (int c = 0; c < 3; c++) s1_sum_q[c] <= sum_c[c];
      s1_last_q <= pos.last;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      total[c] = TOT_W'(mem_rdata[c*SUM_W +: SUM_W]) + TOT_W'(s1_sum_q[c]);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_free) begin
      for (int c = 0; c < 3; c++) out_q[c] <= FW'(total[c][TOT_W-1:2]);
      out_last_q <= s1_last_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.red_out       = out_q[0];
  assign res_o.green_out     = out_q[1];
  assign res_o.blue_out      = out_q[2];
  assign res_o.last_of_frame = out_last_q;

  // even rows write the line store and odd rows read it, never both at once
  a_mem_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("line store read and write in the same cycle");

  // after the last block of a frame the raster restarts at the origin
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pos.emit && pos.last) |=> (slot == '0 && pos.pair_first && !pos.emit))
    else $error("raster did not restart after the last block");

  // a result only comes out of a filled stage 1
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("output valid without a stage 1 item");

endmodule
